// ----- sv/bfha_pkg.sv -----
// Shared types, step codes and constants of the best-fit heap allocator.
package bfha_pkg;

    typedef struct packed {
        logic        kind;
        logic [15:0] request_bytes;
        logic [15:0] payload_offset;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_offset;
    } t_result;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;

    localparam int HEAD_GRAN = 4;
    localparam int HDR_GRAN  = 2;
    localparam int MIN_SPLIT = 3;

    localparam logic [1:0] REG_FIRST_FIT_ADDR = 2'd0;

    // Sequencer steps; the controller state and the datapath command share them.
    localparam int STW = 5;
    localparam logic [STW-1:0] S_IDLE  = 5'd0;
    localparam logic [STW-1:0] S_CLR   = 5'd1;
    localparam logic [STW-1:0] S_INIT  = 5'd2;
    localparam logic [STW-1:0] S_WRD   = 5'd3;
    localparam logic [STW-1:0] S_WEV   = 5'd4;
    localparam logic [STW-1:0] S_PICK  = 5'd5;
    localparam logic [STW-1:0] S_A1    = 5'd6;
    localparam logic [STW-1:0] S_A2    = 5'd7;
    localparam logic [STW-1:0] S_A3    = 5'd8;
    localparam logic [STW-1:0] S_A4    = 5'd9;
    localparam logic [STW-1:0] S_A5    = 5'd10;
    localparam logic [STW-1:0] S_FAIL1 = 5'd11;
    localparam logic [STW-1:0] S_FAIL2 = 5'd12;
    localparam logic [STW-1:0] S_OK    = 5'd13;
    localparam logic [STW-1:0] S_RESP  = 5'd14;
    localparam logic [STW-1:0] S_FRD   = 5'd15;
    localparam logic [STW-1:0] S_FEV   = 5'd16;
    localparam logic [STW-1:0] S_FN    = 5'd17;
    localparam logic [STW-1:0] S_FN2   = 5'd18;
    localparam logic [STW-1:0] S_FN3   = 5'd19;
    localparam logic [STW-1:0] S_M0    = 5'd20;
    localparam logic [STW-1:0] S_M1    = 5'd21;
    localparam logic [STW-1:0] S_M2    = 5'd22;
    localparam logic [STW-1:0] S_MG0   = 5'd23;
    localparam logic [STW-1:0] S_MG1   = 5'd24;
    localparam logic [STW-1:0] S_MG2   = 5'd25;
    localparam logic [STW-1:0] S_N0    = 5'd26;
    localparam logic [STW-1:0] S_N1    = 5'd27;
    localparam logic [STW-1:0] S_N2    = 5'd28;
    localparam logic [STW-1:0] S_END   = 5'd29;

    typedef struct packed {
        logic           load;
        logic [STW-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic kind;
        logic walk_end;
        logic stop;
        logic no_best;
        logic small_left;
        logic pf_zero;
        logic unalloc;
        logic steps_over;
        logic phase;
        logic again;
    } t_stat;

endpackage

// ----- sv/best_fit_heap_allocator_core.sv -----
// Top level of the best-fit heap allocator: sequencer, datapath and register port.
// Allocate walks the free list node by node, then splits the chosen block when enough is left; free
//   walks previous-block links, then runs merge rounds with the blocks on either side.
// Throughput: one transaction at a time; a new start is taken only while idle.
// Reset: a clearing pass over all HEAP_BYTES/8 granules (8192 by default) lays out the head and the
//   one free block; busy stays high meanwhile. Done is high for one cycle; no stall.
module best_fit_heap_allocator_core #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bfha_pkg::t_request i_req,
    output logic               o_busy,
    output logic               o_done,
    output bfha_pkg::t_result  o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bfha_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  r_first_fit;

    // Take the mode register on the access phase of a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_fit <= 1'b0;
        end else if (psel && penable && pwrite && (paddr == REG_FIRST_FIT_ADDR)) begin
            r_first_fit <= pwdata[0];
        end
    end

    assign prdata = {31'd0, r_first_fit};
    assign pready = 1'b1;

    // Sequence each transaction through the controller steps.
    bfha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    // Hold the metadata memories and do the per-step work.
    bfha_datapath #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_first_fit (r_first_fit),
        .o_stat      (stat),
        .o_result    (o_result)
    );

endmodule

// ----- sv/bfha_ctrl.sv -----
// Sequencer state machine of the heap allocator.
module bfha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bfha_pkg::t_stat i_stat,
    output bfha_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);
    import bfha_pkg::*;

    logic [STW-1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_INIT;
            S_CLR:   if (i_stat.clr_last) n_state = S_IDLE;
            S_INIT: begin
                if (i_stat.bad) n_state = S_FAIL2;
                else if (i_stat.kind) n_state = S_FRD;
                else n_state = S_WRD;
            end
            S_WRD:   n_state = i_stat.walk_end ? S_PICK : S_WEV;
            S_WEV:   n_state = i_stat.stop ? S_PICK : S_WRD;
            S_PICK:  n_state = i_stat.no_best ? S_FAIL1 : S_A1;
            S_A1:    n_state = S_A2;
            S_A2:    n_state = S_A3;
            S_A3:    n_state = i_stat.small_left ? S_OK : S_A4;
            S_A4:    n_state = S_A5;
            S_A5:    n_state = S_OK;
            S_FAIL1: n_state = S_RESP;
            S_FAIL2: n_state = S_RESP;
            S_OK:    n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            S_FRD:   n_state = i_stat.pf_zero ? S_FN : S_FEV;
            S_FEV:   n_state = (i_stat.unalloc || i_stat.steps_over) ? S_FN : S_FRD;
            S_FN:    n_state = S_FN2;
            S_FN2:   n_state = S_FN3;
            S_FN3:   n_state = S_M0;
            S_M0:    n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = i_stat.unalloc ? S_MG0 : S_N0;
            S_MG0:   n_state = S_MG1;
            S_MG1:   n_state = S_MG2;
            S_MG2:   n_state = i_stat.phase ? S_END : S_N0;
            S_N0:    n_state = S_N1;
            S_N1:    n_state = S_N2;
            S_N2:    n_state = i_stat.unalloc ? S_MG0 : S_END;
            S_END:   n_state = i_stat.again ? S_M0 : S_OK;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.op   = r_state;
    assign o_cmd.load = (r_state == S_IDLE) && i_start;
    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = (r_state == S_RESP);

endmodule

// ----- sv/bfha_datapath.sv -----
// Heap metadata memories, working registers and step logic of the allocator.
module bfha_datapath #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfha_pkg::t_cmd     i_cmd,
    input  bfha_pkg::t_request i_req,
    input  logic               i_first_fit,
    output bfha_pkg::t_stat    o_stat,
    output bfha_pkg::t_result  o_result
);
    import bfha_pkg::*;

    localparam int GRAN = HEAP_BYTES / 8;
    localparam int GW   = $clog2(GRAN);
    localparam int SW   = GW + 1;
    localparam int CW   = (SW > 14) ? SW : 14;

    logic [GW-1:0] mem_pb [GRAN];
    logic [GW-1:0] mem_nf [GRAN];
    logic [GW-1:0] mem_pf [GRAN];
    logic [SW-1:0] mem_sz [GRAN];
    logic          mem_am [GRAN];

    logic [GW-1:0] q_pb, q_nf, q_pf;
    logic [SW-1:0] q_sz;
    logic          q_am;

    t_request      r_req;
    logic [GW-1:0] r_head, r_cur, r_best, r_pf, r_nf, r_nb, r_nw, r_a, r_b, r_bnf, r_bnb, r_clr;
    logic [CW-1:0] r_need, r_bd;
    logic [SW-1:0] r_steps, r_csize, r_bsz;
    logic          r_phase, r_changed;
    logic [1:0]    r_status;
    logic [15:0]   r_granted;

    function automatic logic [GW-1:0] following(input logic [GW-1:0] x, input logic [SW-1:0] sz);
        logic [SW:0] e;
        e = (SW+1)'(x) + (SW+1)'(sz);
        return (e >= (SW+1)'(GRAN)) ? '0 : e[GW-1:0];
    endfunction

    // Request decode
    logic [16:0]   need_sum;
    logic [CW-1:0] need_c;
    logic [16:0]   fcur_w;
    logic          free_bad;
    logic [GW-1:0] fcur;
    assign need_sum = {1'b0, r_req.request_bytes} + 17'd23;
    assign need_c   = CW'(need_sum[16:3]);
    assign fcur_w   = {4'd0, r_req.payload_offset[15:3]} - 17'(HDR_GRAN);
    assign free_bad = (r_req.payload_offset[2:0] != 3'd0) || (r_req.payload_offset < 16'd16)
                   || (fcur_w < 17'(HEAD_GRAN)) || ({15'd0, fcur_w} >= 32'(GRAN));
    assign fcur     = GW'(fcur_w);

    // Free-list walk evaluation
    logic          fit, better;
    logic [CW-1:0] diff;
    assign fit    = CW'(q_sz) >= r_need;
    assign diff   = CW'(q_sz) - r_need;
    assign better = fit && (diff < r_bd);

    logic [CW:0]   nw_sum;
    logic [GW-1:0] nw_c;
    assign nw_sum = (CW+1)'(r_cur) + (CW+1)'(r_need);
    assign nw_c   = (nw_sum >= (CW+1)'(GRAN)) ? GW'(nw_sum - (CW+1)'(GRAN)) : GW'(nw_sum);

    logic [SW:0]   msum;
    logic [SW-1:0] msat;
    assign msum = (SW+1)'(q_sz) + (SW+1)'(r_bsz);
    assign msat = (msum > (SW+1)'(GRAN)) ? SW'(GRAN) : SW'(msum);

    logic [GW-1:0] nf_c;
    assign nf_c = (r_pf == '0) ? r_head : q_nf;

    logic [31:0] gw;
    assign gw = (32'(r_cur) + 32'(HDR_GRAN)) << 3;

    // Read address
    logic [GW-1:0] rd_addr;
    always_comb begin
        case (i_cmd.op)
            S_PICK:  rd_addr = r_best;
            S_FRD:   rd_addr = r_pf;
            S_FN:    rd_addr = r_pf;
            S_M1:    rd_addr = q_pb;
            S_MG0:   rd_addr = r_b;
            S_MG1:   rd_addr = r_a;
            S_N1:    rd_addr = following(r_cur, q_sz);
            default: rd_addr = r_cur;
        endcase
    end

    // Write ports
    logic          we_pb, we_nf, we_pf, we_sz, we_am;
    logic [GW-1:0] wa_pb, wa_nf, wa_pf, wa_sz, wa_am;
    logic [GW-1:0] wd_pb, wd_nf, wd_pf;
    logic [SW-1:0] wd_sz;
    logic          wd_am;

    always_comb begin
        we_pb = 1'b0; wa_pb = r_cur; wd_pb = '0;
        we_nf = 1'b0; wa_nf = r_cur; wd_nf = '0;
        we_pf = 1'b0; wa_pf = r_cur; wd_pf = '0;
        we_sz = 1'b0; wa_sz = r_cur; wd_sz = '0;
        we_am = 1'b0; wa_am = r_cur; wd_am = 1'b0;
        case (i_cmd.op)
            S_CLR: begin
                we_pb = 1'b1; wa_pb = r_clr;
                we_sz = 1'b1; wa_sz = r_clr;
                we_am = 1'b1; wa_am = r_clr; wd_am = (r_clr == '0);
                if (r_clr == '0) wd_sz = SW'(HEAD_GRAN);
                else if (r_clr == GW'(HEAD_GRAN)) wd_sz = SW'(GRAN - HEAD_GRAN);
                if (r_clr == GW'(HEAD_GRAN)) begin
                    we_nf = 1'b1; wa_nf = r_clr;
                    we_pf = 1'b1; wa_pf = r_clr;
                end
            end
            S_A1: begin
                we_am = 1'b1; wd_am = 1'b1;
            end
            S_A2: begin
                we_nf = (r_pf != '0); wa_nf = r_pf; wd_nf = r_nf;
                we_pf = (r_nf != '0); wa_pf = r_nf; wd_pf = r_pf;
            end
            S_A3: begin
                we_nf = 1'b1;
                we_pf = 1'b1;
            end
            S_A4: begin
                we_am = 1'b1; wa_am = r_nw;
                we_pb = 1'b1; wa_pb = r_nw; wd_pb = r_cur;
                we_nf = 1'b1; wa_nf = r_nw; wd_nf = r_nf;
                we_pf = 1'b1; wa_pf = r_nw; wd_pf = r_pf;
                we_sz = 1'b1; wa_sz = r_nw; wd_sz = r_csize - SW'(r_need);
            end
            S_A5: begin
                we_sz = 1'b1; wd_sz = SW'(r_need);
                we_pb = (r_nb != '0); wa_pb = r_nb; wd_pb = r_nw;
                we_nf = (r_pf != '0); wa_nf = r_pf; wd_nf = r_nw;
                we_pf = (r_nf != '0); wa_pf = r_nf; wd_pf = r_nw;
            end
            S_FN2: begin
                we_am = 1'b1;
                we_nf = (r_pf != '0); wa_nf = r_pf; wd_nf = r_cur;
                we_pf = (nf_c != '0); wa_pf = nf_c; wd_pf = r_cur;
            end
            S_FN3: begin
                we_nf = 1'b1; wd_nf = r_nf;
                we_pf = 1'b1; wd_pf = r_pf;
            end
            S_MG2: begin
                we_nf = 1'b1; wa_nf = r_a; wd_nf = r_bnf;
                we_pb = (r_bnb != '0); wa_pb = r_bnb; wd_pb = r_a;
                we_pf = (r_bnf != '0); wa_pf = r_bnf; wd_pf = r_a;
                we_sz = 1'b1; wa_sz = r_a; wd_sz = msat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_pb) mem_pb[wa_pb] <= wd_pb;
        if (we_nf) mem_nf[wa_nf] <= wd_nf;
        if (we_pf) mem_pf[wa_pf] <= wd_pf;
        if (we_sz) mem_sz[wa_sz] <= wd_sz;
        if (we_am) mem_am[wa_am] <= wd_am;
        q_pb <= mem_pb[rd_addr];
        q_nf <= mem_nf[rd_addr];
        q_pf <= mem_pf[rd_addr];
        q_sz <= mem_sz[rd_addr];
        q_am <= mem_am[rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= GW'(HEAD_GRAN);
            r_clr  <= '0;
        end else begin
            case (i_cmd.op)
                S_CLR: r_clr <= r_clr + 1'b1;
                S_A2:  if (r_pf == '0) r_head <= r_nf;
                S_A5:  if (r_pf == '0) r_head <= r_nw;
                S_FN2: if (r_pf == '0) r_head <= r_cur;
                default: begin
                end
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        case (i_cmd.op)
            S_INIT: begin
                r_need    <= need_c;
                r_cur     <= (r_req.kind == KIND_ALLOC) ? r_head : fcur;
                r_pf      <= fcur;
                r_best    <= '0;
                r_bd      <= '1;
                r_steps   <= '0;
                r_granted <= '0;
            end
            S_WEV: begin
                if (better) begin
                    r_best <= r_cur;
                    r_bd   <= diff;
                end
                r_cur   <= q_nf;
                r_steps <= r_steps + 1'b1;
            end
            S_PICK: r_cur <= r_best;
            S_A1: begin
                r_pf    <= q_pf;
                r_nf    <= q_nf;
                r_csize <= q_sz;
                r_nb    <= following(r_cur, q_sz);
            end
            S_A3: begin
                r_granted <= gw[15:0];
                r_nw      <= nw_c;
            end
            S_FAIL1: begin
                r_status  <= ST_NO_SPACE;
                r_granted <= '0;
            end
            S_FAIL2: begin
                r_status  <= ST_INVALID;
                r_granted <= '0;
            end
            S_OK: r_status <= ST_DONE;
            S_FEV: begin
                if (q_am) begin
                    if (r_steps >= SW'(GRAN)) begin
                        r_pf <= '0;
                    end else begin
                        r_pf    <= q_pb;
                        r_steps <= r_steps + 1'b1;
                    end
                end
            end
            S_FN2: r_nf <= nf_c;
            S_FN3: begin
                r_steps   <= '0;
                r_changed <= 1'b0;
            end
            S_M1: begin
                r_a     <= q_pb;
                r_b     <= r_cur;
                r_phase <= 1'b0;
            end
            S_MG1: begin
                r_bsz <= q_sz;
                r_bnf <= q_nf;
                r_bnb <= following(r_b, q_sz);
            end
            S_MG2: begin
                r_cur     <= r_a;
                r_changed <= 1'b1;
            end
            S_N1: begin
                r_a     <= r_cur;
                r_b     <= following(r_cur, q_sz);
                r_phase <= 1'b1;
            end
            S_END: begin
                r_steps   <= r_steps + 1'b1;
                r_changed <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.clr_last   = (r_clr == GW'(GRAN - 1));
    assign o_stat.bad        = (r_req.kind == KIND_ALLOC) ? (r_req.request_bytes == 16'd0)
                                                          : free_bad;
    assign o_stat.kind       = r_req.kind;
    assign o_stat.walk_end   = (r_cur == '0) || (r_steps >= SW'(GRAN));
    assign o_stat.stop       = (better && (diff < CW'(MIN_SPLIT))) || (fit && i_first_fit);
    assign o_stat.no_best    = (r_best == '0);
    assign o_stat.small_left = (r_bd < CW'(MIN_SPLIT));
    assign o_stat.pf_zero    = (r_pf == '0);
    assign o_stat.unalloc    = !q_am;
    assign o_stat.steps_over = (r_steps >= SW'(GRAN));
    assign o_stat.phase      = r_phase;
    assign o_stat.again      = r_changed && ((SW+1)'(r_steps) + 1'b1 < (SW+1)'(GRAN));

    assign o_result.status         = r_status;
    assign o_result.granted_offset = r_granted;

endmodule
